// ===== hw/rtl/pbffm_pkg.sv =====
// pbffm_pkg: shared constants and codes of the bitmap first-fit page mapper
// used by page_bitmap_first_fit_mapper_unit and tb; pbffm_ram does not use it
// no dependencies
package pbffm_pkg;

	// bitmap geometry
	localparam int NUM_PAGES = 524288;
	localparam int WORD_BITS = 64;
	localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int WIDX_W    = $clog2(NUM_WORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);

	// search group: pages examined per cycle of the group search state
	localparam int GRP_BITS  = 8;
	localparam int GRP_W     = $clog2(GRP_BITS);
	localparam int NUM_GRPS  = WORD_BITS / GRP_BITS;
	localparam int GSEL_W    = $clog2(NUM_GRPS);

	// page arithmetic width: holds (2^33 - 2) >> 12 and run start plus span
	localparam int PG_W      = 22;

	// payload widths
	localparam int ADDR_W    = 32;
	localparam int LEN_W     = 32;
	localparam int SHIFT_W   = 5;
	localparam int WIN_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 19;

	// page shift clamp and register reset values
	localparam logic [SHIFT_W-1:0] SHIFT_MIN       = 5'd12;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX       = 5'd16;
	localparam logic [WIN_W-1:0]   WIN_FIRST_RESET = 19'(32'h40000000 >> 12);
	localparam logic [WIN_W-1:0]   WIN_LAST_RESET  = 19'(32'h6fffffff >> 12);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_SHIFT   = 2'd0,
		CFG_WINDOW_FIRST = 2'd1,
		CFG_WINDOW_LAST  = 2'd2
	} cfg_idx_t;

endpackage

// ===== hw/rtl/pbffm_ram.sv =====
// pbffm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pbffm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/page_bitmap_first_fit_mapper_unit.sv =====
// page_bitmap_first_fit_mapper_unit: page bitmap allocator with first-fit search
// depends on pbffm_pkg and pbffm_ram
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall   | req_addr, req_length, fixed_placement
//   out     | output    | out_valid/out_stall | result_addr, search_failed, range_conflict
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// after reset the bitmap ram is cleared one word a cycle, with in_stall high until all words are clear
// each bitmap word of a range check or mark passes a ram read state, then an evaluate/write state
// the first-fit search reads each bitmap word into a register, then checks it group by group, 8 pages a cycle
// one request at a time
// a finished result waits in the output register while the next request is taken
module page_bitmap_first_fit_mapper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pbffm_pkg::ADDR_W-1:0]    req_addr,
	input  logic [pbffm_pkg::LEN_W-1:0]     req_length,
	input  logic                            fixed_placement,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pbffm_pkg::ADDR_W-1:0]    result_addr,
	output logic                            search_failed,
	output logic                            range_conflict,
	input  logic                            cfg_we,
	input  logic [pbffm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbffm_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int PG_W   = pbffm_pkg::PG_W;
	localparam int PAGE_W = pbffm_pkg::PAGE_W;
	localparam int WIDX_W = pbffm_pkg::WIDX_W;
	localparam int BIT_W  = pbffm_pkg::BIT_W;
	localparam int WB     = pbffm_pkg::WORD_BITS;

	typedef enum logic [11:0] {
		ST_CLR     = 12'b000000000001,
		ST_IDLE    = 12'b000000000010,
		ST_RANGE   = 12'b000000000100,
		ST_PREP    = 12'b000000001000,
		ST_SCAN_RD = 12'b000000010000,
		ST_SCAN_EV = 12'b000000100000,
		ST_SRCH_RD = 12'b000001000000,
		ST_SRCH_LD = 12'b000010000000,
		ST_SRCH_GR = 12'b000100000000,
		ST_FIN     = 12'b001000000000,
		ST_FAIL    = 12'b010000000000,
		ST_START   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [pbffm_pkg::SHIFT_W-1:0] page_shift_q;
	logic [pbffm_pkg::WIN_W-1:0]   win_first_q;
	logic [pbffm_pkg::WIN_W-1:0]   win_last_q;
	logic [pbffm_pkg::SHIFT_W-1:0] sh;

	// request and progress
	logic [pbffm_pkg::ADDR_W-1:0]  addr_q;
	logic [pbffm_pkg::LEN_W-1:0]   len_q;
	logic                          fixed_q;
	logic                          failed_q;
	logic                          conf_q;
	logic                          mark_q;
	logic [PG_W-1:0]               rng_first_q;
	logic [PG_W-1:0]               rng_last_q;
	logic [PG_W-1:0]               span_q;
	logic [WIDX_W-1:0]             lastw_q;
	logic [BIT_W-1:0]              lastb_q;
	logic [WIDX_W-1:0]             wq_q;
	logic [pbffm_pkg::GSEL_W-1:0]  grp_q;
	logic [PG_W-1:0]               rs_q;
	logic [WB-1:0]                 word_q;
	logic [WIDX_W-1:0]             clr_cnt_q;

	// output register
	logic                          out_valid_q;
	logic [pbffm_pkg::ADDR_W-1:0]  result_addr_q;
	logic                          search_failed_q;
	logic                          range_conflict_q;

	// ram
	logic                          mem_we;
	logic [WIDX_W-1:0]             mem_waddr;
	logic [WB-1:0]                 mem_wdata;
	logic                          mem_re;
	logic [WIDX_W-1:0]             mem_raddr;
	logic [WB-1:0]                 mem_rdata;

	// datapath
	logic [pbffm_pkg::ADDR_W:0]    end_sum;
	logic [PG_W-1:0]               first_pg;
	logic [PG_W-1:0]               last_pg;
	logic [PG_W-1:0]               span_pg;
	logic [BIT_W-1:0]              mask_lo;
	logic [BIT_W-1:0]              mask_hi;
	logic [WB-1:0]                 mask;
	logic                          hit;
	logic [PG_W-1:0]               rs_v;
	logic [PG_W-1:0]               start_v;
	logic                          found;
	logic [PG_W-1:0]               pw;
	logic [BIT_W-1:0]              bidx;
	logic                          out_free;
	logic                          accept;
	logic [PG_W-1:0]               np_pg;

	assign np_pg    = PG_W'(pbffm_pkg::NUM_PAGES);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// clamp page shift
	always_comb begin
		if (page_shift_q < pbffm_pkg::SHIFT_MIN) begin
			sh = pbffm_pkg::SHIFT_MIN;
		end else if (page_shift_q > pbffm_pkg::SHIFT_MAX) begin
			sh = pbffm_pkg::SHIFT_MAX;
		end else begin
			sh = page_shift_q;
		end
	end

	// page range of the current address and length
	assign end_sum  = {1'b0, addr_q} + {1'b0, len_q} - 33'd1;
	assign first_pg = PG_W'(addr_q >> sh);
	assign last_pg  = PG_W'(end_sum >> sh);
	assign span_pg  = PG_W'((len_q - 32'd1) >> sh);

	// bit mask of the range within the current word
	always_comb begin
		mask_lo = (wq_q == rng_first_q[PAGE_W-1:BIT_W]) ? rng_first_q[BIT_W-1:0] : '0;
		mask_hi = (wq_q == lastw_q) ? lastb_q : BIT_W'(WB - 1);
		mask    = ({WB{1'b1}} << mask_lo) & ({WB{1'b1}} >> (BIT_W'(WB - 1) - mask_hi));
	end
	assign hit = |(mem_rdata & mask);

	// first-fit over one group of pages
	always_comb begin
		rs_v    = rs_q;
		found   = 1'b0;
		start_v = rs_q;
		pw      = '0;
		bidx    = '0;
		for (int j = 0; j < pbffm_pkg::GRP_BITS; j++) begin
			bidx = {grp_q, pbffm_pkg::GRP_W'(j)};
			pw   = PG_W'({wq_q, bidx});
			if (!found && pw >= PG_W'(win_first_q)) begin
				if (word_q[bidx]) begin
					rs_v = pw + 1'b1;
				end else if (pw >= rs_v + span_q && rs_v <= PG_W'(win_last_q)) begin
					found   = 1'b1;
					start_v = rs_v;
				end
			end
		end
	end

	// ram control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wq_q;
		mem_wdata = mem_rdata | mask;
		mem_re    = 1'b0;
		mem_raddr = wq_q;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_SCAN_RD, ST_SRCH_RD: begin
				mem_re = 1'b1;
			end
			ST_SCAN_EV: begin
				mem_we = mark_q;
			end
			default: begin
			end
		endcase
	end

	pbffm_ram #(
		.WIDTH(WB),
		.DEPTH(pbffm_pkg::NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= pbffm_pkg::SHIFT_MIN;
			win_first_q  <= pbffm_pkg::WIN_FIRST_RESET;
			win_last_q   <= pbffm_pkg::WIN_LAST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pbffm_pkg::CFG_PAGE_SHIFT:   page_shift_q <= cfg_data[pbffm_pkg::SHIFT_W-1:0];
				pbffm_pkg::CFG_WINDOW_FIRST: win_first_q  <= cfg_data[pbffm_pkg::WIN_W-1:0];
				pbffm_pkg::CFG_WINDOW_LAST:  win_last_q   <= cfg_data[pbffm_pkg::WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken; in the finish state the handoff below decides
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == WIDX_W'(pbffm_pkg::NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (mark_q) begin
						state_q <= (rng_first_q >= np_pg) ? ST_FIN : ST_SCAN_RD;
					end else if (fixed_q) begin
						state_q <= ST_PREP;
					end else if (addr_q == '0 || rng_first_q >= np_pg || rng_last_q >= np_pg) begin
						state_q <= ST_START;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					if (!mark_q && hit) begin
						state_q <= ST_START;
					end else if (wq_q == lastw_q) begin
						state_q <= mark_q ? ST_FIN : ST_PREP;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_START: begin
					state_q <= (win_first_q > win_last_q) ? ST_FAIL : ST_SRCH_RD;
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_LD;
				end
				ST_SRCH_LD: begin
					state_q <= ST_SRCH_GR;
				end
				ST_SRCH_GR: begin
					if (found) begin
						state_q <= ST_RANGE;
					end else if (rs_v > PG_W'(win_last_q) ||
						(wq_q == WIDX_W'(pbffm_pkg::NUM_WORDS - 1) &&
						grp_q == pbffm_pkg::GSEL_W'(pbffm_pkg::NUM_GRPS - 1))) begin
						state_q <= ST_FAIL;
					end else if (grp_q == pbffm_pkg::GSEL_W'(pbffm_pkg::NUM_GRPS - 1)) begin
						state_q <= ST_SRCH_RD;
					end
				end
				ST_FAIL: begin
					state_q <= ST_RANGE;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q   <= req_addr;
				len_q    <= (req_length == '0) ? 32'd1 : req_length;
				fixed_q  <= fixed_placement;
				failed_q <= 1'b0;
				conf_q   <= 1'b0;
				mark_q   <= 1'b0;
			end
			ST_RANGE: begin
				rng_first_q <= first_pg;
				rng_last_q  <= last_pg;
				span_q      <= span_pg;
			end
			ST_PREP: begin
				wq_q <= rng_first_q[PAGE_W-1:BIT_W];
				if (mark_q) begin
					conf_q <= (rng_first_q >= np_pg) || (rng_last_q >= np_pg);
				end else if (fixed_q) begin
					mark_q <= 1'b1;
				end
				if (rng_last_q >= np_pg) begin
					lastw_q <= WIDX_W'(pbffm_pkg::NUM_WORDS - 1);
					lastb_q <= BIT_W'(WB - 1);
				end else begin
					lastw_q <= rng_last_q[PAGE_W-1:BIT_W];
					lastb_q <= rng_last_q[BIT_W-1:0];
				end
			end
			ST_SCAN_EV: begin
				if (mark_q) begin
					conf_q <= conf_q | hit;
				end
				if (wq_q == lastw_q && !mark_q && !hit) begin
					mark_q <= 1'b1;
				end
				wq_q <= wq_q + 1'b1;
			end
			ST_START: begin
				rs_q  <= PG_W'(win_first_q);
				wq_q  <= win_first_q[PAGE_W-1:BIT_W];
				grp_q <= win_first_q[BIT_W-1:pbffm_pkg::GRP_W];
			end
			ST_SRCH_LD: begin
				word_q <= mem_rdata;
			end
			ST_SRCH_GR: begin
				rs_q  <= rs_v;
				grp_q <= grp_q + 1'b1;
				if (grp_q == pbffm_pkg::GSEL_W'(pbffm_pkg::NUM_GRPS - 1)) begin
					wq_q <= wq_q + 1'b1;
				end
				if (found) begin
					addr_q <= pbffm_pkg::ADDR_W'(start_v) << sh;
					mark_q <= 1'b1;
				end
			end
			ST_FAIL: begin
				addr_q   <= '0;
				failed_q <= 1'b1;
				mark_q   <= 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					result_addr_q    <= addr_q;
					search_failed_q  <= failed_q;
					range_conflict_q <= conf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign result_addr    = result_addr_q;
	assign search_failed  = search_failed_q;
	assign range_conflict = range_conflict_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_write_only_clear_or_mark: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR || (state_q == ST_SCAN_EV && mark_q)))
		else $error("bitmap written outside clear or mark");

	a_no_search_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH_GR || state_q == ST_START) |-> !fixed_q)
		else $error("search entered for a fixed request");

	a_failed_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && failed_q) |-> (addr_q == '0))
		else $error("failed search with nonzero address");

	a_result_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result left while output register was full");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench of page_bitmap_first_fit_mapper_unit
// keeps its own page bitmap and first-fit predictor; depends on pbffm_pkg and the rtl
`timescale 1ns / 100ps

module tb;
	import pbffm_pkg::*;

	localparam int                   IDLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 2'd3;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              fixed;
	} map_req_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              failed;
		logic              conflict;
	} placement_t;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall;
	logic [ADDR_W-1:0]    req_addr;
	logic [LEN_W-1:0]     req_length;
	logic                 fixed_placement;
	logic                 out_valid, out_stall;
	logic [ADDR_W-1:0]    result_addr;
	logic                 search_failed, range_conflict;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	page_bitmap_first_fit_mapper_unit dut (.*);

	// predictor state: page bitmap and register copies
	bit              page_map [NUM_PAGES];
	logic [4:0]      shift_reg;
	logic [WIN_W-1:0] win_first, win_last;

	map_req_t   pending_reqs[$];
	placement_t expected_places[$];
	int send_pct, recv_pct;
	int hold_req, hold_seen, hold_left;
	int errors, n_results, n_failed, n_conflict;
	int idle_cycles;
	bit in_took;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_shift();
		if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
		if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
		return shift_reg;
	endfunction

	function automatic bit page_taken(logic [63:0] p);
		if (p >= NUM_PAGES) return 1;
		return page_map[p];
	endfunction

	function automatic bit pages_free(logic [63:0] first, logic [63:0] last);
		for (logic [63:0] p = first; p <= last; p++)
			if (page_taken(p)) return 0;
		return 1;
	endfunction

	function automatic bit first_fit(logic [63:0] span, output logic [63:0] start);
		logic [63:0] run;
		run = 0;
		start = 0;
		if (win_first > win_last) return 0;
		for (logic [63:0] q = win_first; q <= win_last + span; q++) begin
			if (q >= NUM_PAGES) return 0;
			if (page_taken(q)) run = 0;
			else begin
				run++;
				if (run > span) begin
					start = q - span;
					return 1;
				end
			end
		end
		return 0;
	endfunction

	// place one request and mark its pages
	function automatic placement_t place_request(map_req_t r);
		placement_t  o;
		logic [63:0] a, l, first, last, start;
		int          sh;
		bit          mv;
		sh = eff_shift();
		a = r.addr;
		l = (r.len == 0) ? 64'd1 : 64'(r.len);
		o.failed = 0;
		if (!r.fixed) begin
			mv = (a == 0) || !pages_free(a >> sh, (a + l - 1) >> sh);
			if (mv) begin
				if (first_fit((l - 1) >> sh, start)) a = (start << sh) & 64'hffffffff;
				else begin
					a = 0;
					o.failed = 1;
				end
			end
		end
		first = a >> sh;
		last = (a + l - 1) >> sh;
		o.conflict = !pages_free(first, last);
		for (logic [63:0] p = first; p <= last && p < NUM_PAGES; p++)
			page_map[p] = 1;
		o.addr = a[31:0];
		return o;
	endfunction

	// accept flag and prediction at the rising edge
	always @(posedge clk) begin
		in_took = in_valid && !in_stall;
		if (in_took)
			expected_places.push_back(place_request('{req_addr, req_length, fixed_placement}));
	end

	// driver: new beat once the previous one is gone
	always @(negedge clk or negedge arst_n) begin
		map_req_t r;
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_took) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_pct) begin
				r = pending_reqs.pop_front();
				req_addr <= r.addr;
				req_length <= r.len;
				fixed_placement <= r.fixed;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	// monitor: compare each result beat with the oldest placement
	always @(posedge clk) begin
		placement_t e;
		if (out_valid && !out_stall) begin
			if (expected_places.size() == 0) begin
				$error("result beat with no request pending, addr %h", result_addr);
				errors++;
			end else begin
				e = expected_places.pop_front();
				n_results++;
				n_failed += e.failed;
				n_conflict += e.conflict;
				if (result_addr !== e.addr) begin
					$error("result_addr expected %h actual %h", e.addr, result_addr);
					errors++;
				end
				if (search_failed !== e.failed) begin
					$error("search_failed expected %b actual %b", e.failed, search_failed);
					errors++;
				end
				if (range_conflict !== e.conflict) begin
					$error("range_conflict expected %b actual %b", e.conflict, range_conflict);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (in_valid && !in_stall || out_valid && !out_stall) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_PAGE_SHIFT) shift_reg = val[4:0];
		else if (idx == CFG_WINDOW_FIRST) win_first = val;
		else if (idx == CFG_WINDOW_LAST) win_last = val;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_places.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_req(logic [31:0] a, logic [31:0] l, logic f);
		pending_reqs.push_back('{a, l, f});
	endtask

	// mostly well-formed small requests around the window, some noise
	task automatic add_random(int n);
		int          sh, k;
		logic [31:0] a, l;
		for (int i = 0; i < n; i++) begin
			sh = eff_shift();
			k = $urandom_range(99);
			l = $urandom_range(1, 4 << sh);
			if (k < 45) begin
				add_req(0, l, 0);
			end else if (k < 70) begin
				a = ((win_first + $urandom_range(300)) << sh) | $urandom_range((1 << sh) - 1);
				add_req(a, l, 0);
			end else if (k < 85) begin
				a = ($urandom_range(4095) << sh) | $urandom_range((1 << sh) - 1);
				add_req(a, l, 1);
			end else if (k < 95) begin
				add_req($urandom, l, $urandom_range(1));
			end else begin
				add_req(0, $urandom_range(0, 64 << sh), 0);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_PAGE_SHIFT;
		cfg_data = 0;
		out_stall = 1;
		req_addr = 0;
		req_length = 0;
		fixed_placement = 0;
		send_pct = 14;
		recv_pct = 87;
		shift_reg = SHIFT_MIN;
		win_first = WIN_FIRST_RESET;
		win_last = WIN_LAST_RESET;
		repeat (7) @(negedge clk);
		arst_n = 1;

		// directed: extremes and special cases at reset settings
		add_req(0, 1, 0);
		add_req(0, 0, 0);                       // zero length
		add_req(32'h40000000, 32'h1000, 0);     // page already taken, moved
		add_req(32'h40000000, 32'h1000, 1);     // fixed onto a used page
		add_req(32'h00001fff, 32'h2001, 1);     // fixed, crosses pages
		add_req(32'h00001000, 32'h1000, 0);     // page used by the previous request, moved
		add_req(32'h80000000, 32'h80000000, 1); // beyond the bitmap
		add_req(32'hffffffff, 32'hffffffff, 1); // top address, full length
		add_req(32'h7ffff000, 32'h2000, 1);     // straddles the bitmap end
		add_req(32'hfffff000, 32'h1000, 0);     // beyond, gets moved
		add_req(32'h55555555, 32'h0000aaaa, 0);
		add_req(32'haaaaaaaa, 32'h00005555, 1);
		add_req(0, 32'h00100000, 0);            // 256-page run
		add_req(0, 32'h00001001, 0);
		drain();
		write_reg(CFG_WINDOW_FIRST, 19'd524287);
		write_reg(CFG_WINDOW_LAST, 19'd524287);
		add_req(0, 1, 0);                       // last page of the bitmap
		add_req(0, 1, 0);                       // window full: search fails
		add_req(0, 32'h2000, 0);                // run runs off the end
		drain();
		write_reg(CFG_WINDOW_FIRST, WIN_FIRST_RESET);
		write_reg(CFG_WINDOW_LAST, WIN_LAST_RESET);

		// random, sender mostly ready, receiver mostly stalled, plus long hold
		add_random(60);
		hold_req++;
		add_random(140);
		drain();

		// largest page size, widest window; receiver mostly ready
		send_pct = 87;
		recv_pct = 14;
		write_reg(CFG_PAGE_SHIFT, 19'h0001f);
		write_reg(CFG_WINDOW_FIRST, 19'd0);
		write_reg(CFG_WINDOW_LAST, 19'h7ffff);
		add_random(190);
		drain();

		// shift below the minimum, window near the top; no idling
		send_pct = 0;
		recv_pct = 0;
		write_reg(CFG_PAGE_SHIFT, 19'h7ffe0);
		write_reg(CFG_WINDOW_FIRST, 19'd500000);
		write_reg(CFG_WINDOW_LAST, 19'd524287);
		write_reg(CFG_NONE, 19'h5a5a5);
		add_random(100);
		drain();

		// empty window, mid page size
		write_reg(CFG_PAGE_SHIFT, 19'd14);
		write_reg(CFG_WINDOW_FIRST, 19'd1000);
		write_reg(CFG_WINDOW_LAST, 19'd10);
		add_random(73);
		drain();
		repeat (50) @(negedge clk);

		$display("covered %0d results: %0d failed searches, %0d range conflicts",
			n_results, n_failed, n_conflict);
		$display("page shifts 12 to 16 incl. clamped, windows wide, top, empty and default");
		if (errors == 0 && expected_places.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
